// ===== sv/tfrm_pkg.sv =====
// types and constants for the typed field rule matcher
// no dependencies
package tfrm_pkg;
  localparam logic [3:0] OP_EQ = 4'd0;
  localparam logic [3:0] OP_NE = 4'd1;
  localparam logic [3:0] OP_LT = 4'd2;
  localparam logic [3:0] OP_LE = 4'd3;
  localparam logic [3:0] OP_GT = 4'd4;
  localparam logic [3:0] OP_GE = 4'd5;
  localparam logic [3:0] OP_IN = 4'd6;
  localparam logic [3:0] OP_NIN = 4'd7;

  localparam logic [2:0] CLS_UNS = 3'd0;
  localparam logic [2:0] CLS_SGN = 3'd1;
  localparam logic [2:0] CLS_FLT = 3'd2;
  localparam logic [2:0] CLS_MAC = 3'd3;
  localparam logic [2:0] CLS_IP4 = 3'd4;
  localparam logic [2:0] CLS_IP6 = 3'd5;

  localparam logic [1:0] ADDR_OP = 2'd0;
  localparam logic [1:0] ADDR_CLS = 2'd1;
  localparam logic [1:0] ADDR_LEN = 2'd2;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SCAN, ST_OUT} state_t;
endpackage

// ===== sv/tfrm_ram.sv =====
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module tfrm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/typed_field_rule_matcher.sv =====
// typed field rule matcher: one shared compare unit walks the value table
// uses tfrm_pkg and tfrm_ram
// a load word is written to the table when accepted; a test word goes from READ
//   straight to OUT when decided without a table compare, else through SCAN, where the
//   list operators walk n = min(list_length, LIST_DEPTH) entries, one compare per entry
// in_tready is high only in IDLE, so a new word waits until the last result is taken
// reset: synchronous active-low; state and config registers reset, captured input word and table contents undefined
module typed_field_rule_matcher #(
  parameter int LIST_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: value_low[63:0], value_high[127:64], record_class[130:128], pad
  input  logic [135:0] in_tdata,
  // tuser: func[0], entry_index[4:1]
  input  logic [4:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: match[0], class_mismatch[1], pad
  output logic [7:0]   out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  tfrm_pkg::state_t st_r, st_nxt;
  logic [3:0]  op_r;
  logic [2:0]  cls_r;
  logic [4:0]  len_r;
  logic [63:0] lo_r, hi_r;
  logic [2:0]  rcls_r;
  logic [CW-1:0] idx_r, idx_nxt, n_lim;
  logic found_r, found_nxt, match_r, mis_r, res_nxt, mis_nxt;
  logic [127:0] rdata;
  logic eq, lt, gt, ordered;
  logic [AW-1:0] raddr;
  logic in_acc, wr_en;

  assign cfg_pready = 1'b1;
  assign in_tready = (st_r == tfrm_pkg::ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign wr_en = in_acc && !in_tuser[0] && (32'(in_tuser[4:1]) < 32'(LIST_DEPTH));
  assign n_lim = ({27'd0, len_r} > 32'(LIST_DEPTH)) ? CW'(LIST_DEPTH) : CW'(len_r);
  assign raddr = AW'(idx_nxt);

  tfrm_ram #(.WIDTH(128), .DEPTH(LIST_DEPTH)) u_ram (
    .clk(clk), .we(wr_en), .waddr(AW'(in_tuser[4:1])),
    .wdata(in_tdata[127:0]), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    cfg_prdata = 32'd0;
    case (cfg_paddr[3:2])
      tfrm_pkg::ADDR_OP:  cfg_prdata = {28'd0, op_r};
      tfrm_pkg::ADDR_CLS: cfg_prdata = {29'd0, cls_r};
      tfrm_pkg::ADDR_LEN: cfg_prdata = {27'd0, len_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // shared compare unit against the word read from the table
  logic [63:0] e;
  logic a_nan, b_nan, a_zero, b_zero;
  assign e = rdata[63:0];
  always_comb begin
    a_nan = (lo_r[62:52] == 11'h7ff) && (lo_r[51:0] != 52'd0);
    b_nan = (e[62:52] == 11'h7ff) && (e[51:0] != 52'd0);
    a_zero = (lo_r[62:0] == 63'd0);
    b_zero = (e[62:0] == 63'd0);
    lt = 1'b0; gt = 1'b0; eq = 1'b0; ordered = 1'b1;
    case (cls_r)
      tfrm_pkg::CLS_UNS: begin
        eq = lo_r == e; lt = lo_r < e; gt = lo_r > e;
      end
      tfrm_pkg::CLS_SGN: begin
        eq = lo_r == e; lt = $signed(lo_r) < $signed(e); gt = $signed(lo_r) > $signed(e);
      end
      tfrm_pkg::CLS_FLT: begin
        if (a_nan || b_nan) begin
          eq = 1'b0;
        end else if (a_zero && b_zero) begin
          eq = 1'b1;
        end else begin
          eq = lo_r == e;
          if (lo_r[63] != e[63]) begin
            lt = lo_r[63]; gt = e[63];
          end else if (!lo_r[63]) begin
            lt = lo_r[62:0] < e[62:0]; gt = lo_r[62:0] > e[62:0];
          end else begin
            lt = lo_r[62:0] > e[62:0]; gt = lo_r[62:0] < e[62:0];
          end
        end
      end
      tfrm_pkg::CLS_MAC: begin eq = lo_r[47:0] == e[47:0]; ordered = 1'b0; end
      tfrm_pkg::CLS_IP4: begin eq = lo_r[31:0] == e[31:0]; ordered = 1'b0; end
      default: begin eq = (lo_r == e) && (hi_r == rdata[127:64]); ordered = 1'b0; end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tfrm_pkg::ST_IDLE:
        if (in_acc && in_tuser[0]) st_nxt = tfrm_pkg::ST_READ;
      tfrm_pkg::ST_READ:
        if (rcls_r != cls_r || rcls_r > tfrm_pkg::CLS_IP6) st_nxt = tfrm_pkg::ST_OUT;
        else if ((op_r == tfrm_pkg::OP_IN || op_r == tfrm_pkg::OP_NIN) && n_lim == '0)
          st_nxt = tfrm_pkg::ST_OUT;
        else if (op_r > tfrm_pkg::OP_NIN) st_nxt = tfrm_pkg::ST_OUT;
        else st_nxt = tfrm_pkg::ST_SCAN;
      tfrm_pkg::ST_SCAN:
        if (!(op_r == tfrm_pkg::OP_IN || op_r == tfrm_pkg::OP_NIN) || idx_r + 1'b1 >= n_lim)
          st_nxt = tfrm_pkg::ST_OUT;
      tfrm_pkg::ST_OUT:
        if (out_tready) st_nxt = tfrm_pkg::ST_IDLE;
      default: st_nxt = tfrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = '0;
    found_nxt = found_r;
    res_nxt = match_r;
    mis_nxt = mis_r;
    case (st_r)
      tfrm_pkg::ST_IDLE: found_nxt = 1'b0;
      tfrm_pkg::ST_READ: begin
        mis_nxt = rcls_r != cls_r;
        res_nxt = (op_r == tfrm_pkg::OP_NIN) && rcls_r == cls_r && rcls_r <= tfrm_pkg::CLS_IP6;
      end
      tfrm_pkg::ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        found_nxt = found_r | eq;
        case (op_r)
          tfrm_pkg::OP_EQ:  res_nxt = eq;
          tfrm_pkg::OP_NE:  res_nxt = !eq;
          tfrm_pkg::OP_LT:  res_nxt = ordered && lt;
          tfrm_pkg::OP_LE:  res_nxt = ordered && (lt || eq);
          tfrm_pkg::OP_GT:  res_nxt = ordered && gt;
          tfrm_pkg::OP_GE:  res_nxt = ordered && (gt || eq);
          tfrm_pkg::OP_IN:  res_nxt = found_r | eq;
          tfrm_pkg::OP_NIN: res_nxt = !(found_r | eq);
          default:          res_nxt = 1'b0;
        endcase
      end
      default: idx_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tfrm_pkg::ST_IDLE;
      op_r <= 4'd0; cls_r <= 3'd0; len_r <= 5'd1;
      idx_r <= '0; found_r <= 1'b0; match_r <= 1'b0; mis_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      found_r <= found_nxt;
      match_r <= res_nxt;
      mis_r <= mis_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[3:2])
          tfrm_pkg::ADDR_OP:  op_r <= cfg_pwdata[3:0];
          tfrm_pkg::ADDR_CLS: cls_r <= cfg_pwdata[2:0];
          tfrm_pkg::ADDR_LEN: len_r <= cfg_pwdata[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lo_r <= in_tdata[63:0];
      hi_r <= in_tdata[127:64];
      rcls_r <= in_tdata[130:128];
    end
  end

  assign out_tvalid = (st_r == tfrm_pkg::ST_OUT);
  assign out_tdata = {6'd0, mis_r, match_r};
endmodule

// ===== sv/tfrm_checker.sv =====
// port-level checks for the typed field rule matcher
// binds to typed_field_rule_matcher
module tfrm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed");
  a_mis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0]) else $error("match with class mismatch");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0) else $error("pad bits set");
endmodule

bind typed_field_rule_matcher tfrm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== tb/tb.sv =====
// testbench for typed_field_rule_matcher: loads the value table, then runs
// rule tests over many register settings and checks each result word
// depends on tfrm_pkg and the matcher rtl
`timescale 1ns / 100ps

module tb;
  typedef struct packed {
    logic        func;
    logic [3:0]  idx;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [2:0]  cls;
  } rule_word_t;

  typedef struct packed {
    logic mism;
    logic hit;
  } verdict_t;

  localparam int DEPTH = 16;
  localparam int LIMIT = 600000;
  localparam int SETTLE = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic [4:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  typed_field_rule_matcher dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rule_word_t pending_q[$];
  verdict_t verdict_q[$];
  rule_word_t cur_word;

  // predictor state
  logic [63:0] tbl_lo[DEPTH];
  logic [63:0] tbl_hi[DEPTH];
  logic [3:0] rule_op = tfrm_pkg::OP_EQ;
  logic [2:0] rule_cls = tfrm_pkg::CLS_UNS;
  logic [4:0] rule_len = 5'd1;

  // shadow of the table as seen by the stimulus generator
  logic [63:0] gen_lo[DEPTH];
  logic [63:0] gen_hi[DEPTH];

  int errors = 0;
  int cycles = 0;
  logic calm_send = 1'b0;
  logic calm_recv = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;

  function automatic logic same_entry(logic [2:0] c, logic [63:0] lo, logic [63:0] hi, int i);
    logic [63:0] e;
    e = tbl_lo[i];
    case (c)
      tfrm_pkg::CLS_UNS, tfrm_pkg::CLS_SGN: return lo == e;
      tfrm_pkg::CLS_FLT: return $bitstoreal(lo) == $bitstoreal(e);
      tfrm_pkg::CLS_MAC: return lo[47:0] == e[47:0];
      tfrm_pkg::CLS_IP4: return lo[31:0] == e[31:0];
      default: return lo == e && hi == tbl_hi[i];
    endcase
  endfunction

  function automatic logic ordered_hit(logic [2:0] c, logic [3:0] op, logic [63:0] lo);
    logic lt, eq, gt;
    logic [63:0] e;
    real a, b;
    e = tbl_lo[0];
    a = $bitstoreal(lo);
    b = $bitstoreal(e);
    if (c == tfrm_pkg::CLS_UNS) begin
      lt = lo < e; eq = lo == e; gt = lo > e;
    end else if (c == tfrm_pkg::CLS_SGN) begin
      lt = $signed(lo) < $signed(e); eq = lo == e; gt = $signed(lo) > $signed(e);
    end else if (c == tfrm_pkg::CLS_FLT) begin
      lt = a < b; eq = a == b; gt = a > b;
    end else begin
      return 1'b0;
    end
    case (op)
      tfrm_pkg::OP_LT: return lt;
      tfrm_pkg::OP_LE: return lt | eq;
      tfrm_pkg::OP_GT: return gt;
      default: return gt | eq;
    endcase
  endfunction

  function automatic verdict_t judge_rule(rule_word_t w);
    verdict_t v;
    int n;
    logic found;
    v = '0;
    found = 1'b0;
    n = (rule_len > DEPTH) ? DEPTH : rule_len;
    if (w.cls != rule_cls) begin
      v.mism = 1'b1;
      return v;
    end
    if (w.cls > tfrm_pkg::CLS_IP6) return v;
    case (rule_op)
      tfrm_pkg::OP_EQ: v.hit = same_entry(w.cls, w.lo, w.hi, 0);
      tfrm_pkg::OP_NE: v.hit = !same_entry(w.cls, w.lo, w.hi, 0);
      tfrm_pkg::OP_LT, tfrm_pkg::OP_LE, tfrm_pkg::OP_GT, tfrm_pkg::OP_GE:
        v.hit = ordered_hit(w.cls, rule_op, w.lo);
      tfrm_pkg::OP_IN, tfrm_pkg::OP_NIN: begin
        for (int i = 0; i < n; i++)
          if (same_entry(w.cls, w.lo, w.hi, i)) found = 1'b1;
        v.hit = (rule_op == tfrm_pkg::OP_IN) ? found : !found;
      end
      default: v.hit = 1'b0;
    endcase
    return v;
  endfunction

  function automatic int draw_idle(logic calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // sender
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      if (!cur_word.func) begin
        tbl_lo[cur_word.idx] = cur_word.lo;
        tbl_hi[cur_word.idx] = cur_word.hi;
      end else begin
        verdict_q.push_back(judge_rule(cur_word));
      end
    end
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_word = pending_q.pop_front();
        in_tdata <= {5'd0, cur_word.cls, cur_word.hi, cur_word.lo};
        in_tuser <= {cur_word.idx, cur_word.func};
        in_tvalid <= 1'b1;
        send_gap <= draw_idle(calm_send);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    verdict_t want;
    int s;
    if (out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want.hit || out_tdata[1] !== want.mism) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: match exp %b got %b, class_mismatch exp %b got %b",
                     want.hit, out_tdata[0], want.mism, out_tdata[1]);
        end
      end
      s = draw_idle(calm_recv);
      out_tready <= (s == 0);
      recv_stall <= (s == 0) ? 0 : s - 1;
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      out_tready <= (recv_stall == 1);
    end else if (rst_n) begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] reg_idx, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (reg_idx)
      tfrm_pkg::ADDR_OP: rule_op = data[3:0];
      tfrm_pkg::ADDR_CLS: rule_cls = data[2:0];
      default: rule_len = data[4:0];
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // block until every word is sent and every result is back, then settle
  task automatic drain_all();
    do @(negedge clk); while (pending_q.size() != 0 || in_tvalid || verdict_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_load(int i, logic [63:0] lo, logic [63:0] hi);
    rule_word_t w;
    w = '{func: 1'b0, idx: i[3:0], lo: lo, hi: hi, cls: 3'($urandom_range(0, 7))};
    gen_lo[i] = lo;
    gen_hi[i] = hi;
    pending_q.push_back(w);
  endtask

  task automatic push_test(logic [2:0] c, logic [63:0] lo, logic [63:0] hi);
    rule_word_t w;
    w = '{func: 1'b1, idx: 4'($urandom_range(0, 15)), lo: lo, hi: hi, cls: c};
    pending_q.push_back(w);
  endtask

  function automatic logic [63:0] special_bits();
    case ($urandom_range(0, 8))
      0: return 64'h0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return 64'h7ff8_0000_0000_0000;
      5: return 64'h7ff0_0000_0000_0000;
      6: return 64'hfff0_0000_0000_0000;
      7: return 64'h3ff0_0000_0000_0000;
      default: return 64'h0000_0000_0000_0001;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // near a stored value: copies, off by one, random or special bit patterns, or noise above the class width
  function automatic logic [63:0] pick_value(logic [2:0] c, int i);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = rand64();
      1: v = special_bits();
      2: v = gen_lo[i] + 64'(int'($urandom_range(0, 2)) - 1);
      default: v = gen_lo[i];
    endcase
    if ($urandom_range(0, 1)) begin
      if (c == tfrm_pkg::CLS_MAC) v[63:48] = 16'($urandom);
      else if (c == tfrm_pkg::CLS_IP4) v[63:32] = $urandom;
    end
    return v;
  endfunction

  initial begin
    logic [2:0] c;
    logic [63:0] hi;
    int i;
    for (int k = 0; k < DEPTH; k++) begin
      gen_lo[k] = '0;
      gen_hi[k] = '0;
      tbl_lo[k] = '0;
      tbl_hi[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fill every slot, the first four with edge values, then five tests
    reg_write(tfrm_pkg::ADDR_OP, tfrm_pkg::OP_IN);
    reg_write(tfrm_pkg::ADDR_CLS, tfrm_pkg::CLS_FLT);
    reg_write(tfrm_pkg::ADDR_LEN, 32'd16);
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0: push_load(k, 64'h0, 64'h0);
        1: push_load(k, '1, '1);
        2: push_load(k, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        3: push_load(k, 64'h7ff8_0000_0000_0000, 64'h1);
        default: push_load(k, rand64(), rand64());
      endcase
    end
    push_test(tfrm_pkg::CLS_FLT, 64'h8000_0000_0000_0000, 64'h0);
    push_test(tfrm_pkg::CLS_FLT, 64'h7ff8_0000_0000_0000, 64'h0);
    push_test(tfrm_pkg::CLS_FLT, '1, '1);
    push_test(tfrm_pkg::CLS_UNS, 64'h0, 64'h0);
    push_test(3'd7, 64'h0, 64'h0);
    drain_all();

    for (int p = 0; p < 40; p++) begin
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      reg_write(tfrm_pkg::ADDR_OP, (p == 39) ? 32'd15 : 32'(p % 16));
      reg_write(tfrm_pkg::ADDR_CLS, (p == 39) ? 32'd7 : 32'((p * 3) % 8));
      case (p)
        0: reg_write(tfrm_pkg::ADDR_LEN, 32'd0);
        1: reg_write(tfrm_pkg::ADDR_LEN, 32'd16);
        2, 39: reg_write(tfrm_pkg::ADDR_LEN, 32'd31);
        default: reg_write(tfrm_pkg::ADDR_LEN, $urandom_range(0, 31));
      endcase
      for (int n = 0; n < 33; n++) begin
        i = $urandom_range(0, DEPTH - 1);
        if ($urandom_range(0, 3) == 0) begin
          push_load(i, pick_value(rule_cls, i), $urandom_range(0, 1) ? gen_hi[i] : rand64());
        end else begin
          c = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) : rule_cls;
          hi = $urandom_range(0, 2) ? gen_hi[i] : rand64();
          push_test(c, pick_value(c, i), hi);
        end
      end
      drain_all();
    end

    if (verdict_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
